// ===== rtl/core/deterministic_primality_test_unit_defines.svh =====
// assertion macros for the primality test unit
`ifndef DETERMINISTIC_PRIMALITY_TEST_UNIT_DEFINES_SVH
`define DETERMINISTIC_PRIMALITY_TEST_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DPT_ASSERT(label, clk_s, rst_s, prop) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error("%m failed");
`define DPT_ASSERT_ALWAYS(label, clk_s, prop) \
  label: assert property (@(posedge clk_s) prop) else $error("%m failed");
`else
`define DPT_ASSERT(label, clk_s, rst_s, prop)
`define DPT_ASSERT_ALWAYS(label, clk_s, prop)
`endif
`endif

// ===== rtl/core/dpt_pkg.sv =====
// shared types and constants of the primality test unit
`timescale 1ns / 1ps
package dpt_pkg;
  localparam int BASE_COUNT = 12;
  localparam int SMALL_LIMIT = 40;
  localparam int BASE_IDX_W = 4;
  localparam int BASE_W = 6;

  // fixed witness bases
  function automatic logic [BASE_W-1:0] base_prime(input logic [BASE_IDX_W-1:0] idx);
    logic [BASE_W-1:0] b;
    case (idx)
      4'd0: b = 6'd2;
      4'd1: b = 6'd3;
      4'd2: b = 6'd5;
      4'd3: b = 6'd7;
      4'd4: b = 6'd11;
      4'd5: b = 6'd13;
      4'd6: b = 6'd17;
      4'd7: b = 6'd19;
      4'd8: b = 6'd23;
      4'd9: b = 6'd29;
      4'd10: b = 6'd31;
      4'd11: b = 6'd37;
      default: b = 6'd2;
    endcase
    return b;
  endfunction

  typedef enum logic [3:0] {
    ST_IDLE, ST_SMALL, ST_REDUCE, ST_ODD, ST_POW_MUL, ST_POW_SQR,
    ST_CHECK, ST_SQ_LOOP, ST_DONE
  } seq_state_t;

  // handshake between sequencer and modular multiplier
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } mul_ctl_t;
endpackage

// ===== rtl/core/deterministic_primality_test_unit.sv =====
// Deterministic Miller-Rabin test over twelve fixed bases for values of up to
// VALUE_WIDTH bits. One candidate at a time: busy stays high from acceptance until
// out_valid pulses for one cycle with out_prime; the receiver cannot stall, so the
// result must be sampled in that cycle. Each modular product runs in the single
// shift-add multiplier, and a round takes about 2*VALUE_WIDTH products plus a
// remainder pass over the candidate bits; values up to 40 skip the rounds, even
// values fail in the first remainder pass, and early-failing values stop at the
// failing round.
`timescale 1ns / 1ps
module deterministic_primality_test_unit #(
  parameter int VALUE_WIDTH = 63
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_candidate,
  output logic                   out_valid,
  output logic                   out_prime
);
  logic mul_start;
  logic [VALUE_WIDTH-1:0] mul_x, mul_y, mul_m, mul_prod;
  dpt_pkg::mul_ctl_t mul_ctl;

  // sequencer
  dpt_seq #(.W(VALUE_WIDTH)) u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .cand(in_candidate),
    .busy(busy), .res_valid(out_valid), .res_prime(out_prime),
    .mul_start(mul_start), .mul_x(mul_x), .mul_y(mul_y), .mul_m(mul_m),
    .mul_prod(mul_prod), .mul_ctl(mul_ctl)
  );

  // shared modular multiplier
  dpt_modmul #(.W(VALUE_WIDTH)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .x(mul_x), .y(mul_y),
    .m(mul_m), .prod(mul_prod), .ctl(mul_ctl)
  );
endmodule

// ===== rtl/core/dpt_modmul.sv =====
// shift-add modular multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`include "deterministic_primality_test_unit_defines.svh"
module dpt_modmul #(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic [W-1:0] prod,
  output dpt_pkg::mul_ctl_t ctl
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] acc_r, acc_nxt;
  logic [W-1:0] x_r, y_r, m_r;
  logic [CW-1:0] cnt_r;
  logic busy_r, done_r;
  logic [W:0] dbl, dbl_red, add, add_red;

  // double, reduce, conditionally add, reduce
  always_comb begin
    dbl = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m_r}) ? dbl - {1'b0, m_r} : dbl;
    add = dbl_red + {1'b0, x_r};
    add_red = (add >= {1'b0, m_r}) ? add - {1'b0, m_r} : add;
    acc_nxt = y_r[W-1] ? add_red[W-1:0] : dbl_red[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      acc_r <= '0;
      x_r <= x;
      y_r <= y;
      m_r <= m;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      y_r <= {y_r[W-2:0], 1'b0};
    end
  end

  assign prod = acc_r;
  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign ctl.done = done_r;

  `DPT_ASSERT(a_done_after_busy, clk, rst_n, done_r |-> $past(busy_r))
  `DPT_ASSERT(a_no_done_busy, clk, rst_n, !(done_r && busy_r))
  `DPT_ASSERT(a_acc_below_mod, clk, rst_n, busy_r |-> acc_r < m_r)
endmodule

// ===== rtl/core/dpt_seq.sv =====
// round sequencer: small values, divisibility, exponentiation, squaring chain
`timescale 1ns / 1ps
`include "deterministic_primality_test_unit_defines.svh"
module dpt_seq #(
  parameter int W = 63
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] cand,
  output logic         busy,
  output logic         res_valid,
  output logic         res_prime,
  output logic         mul_start,
  output logic [W-1:0] mul_x,
  output logic [W-1:0] mul_y,
  output logic [W-1:0] mul_m,
  input  logic [W-1:0] mul_prod,
  input  dpt_pkg::mul_ctl_t mul_ctl
);
  localparam int SW = $clog2(W + 1);
  localparam int RW = dpt_pkg::BASE_W + 1;

  dpt_pkg::seq_state_t st_r, st_nxt;
  logic [W-1:0] n_r, d_r, d_nxt, e_r, e_nxt, p_r, p_nxt, b_r, b_nxt;
  logic [SW-1:0] s_r, s_nxt, t_r, t_nxt;
  logic [dpt_pkg::BASE_IDX_W-1:0] bi_r, bi_nxt;
  logic [SW-1:0] bit_r, bit_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic pend_r, pend_nxt;
  logic prime_r, prime_nxt, vld_r, vld_nxt;
  logic [dpt_pkg::BASE_W-1:0] base;
  logic [RW:0] rem2;
  logic [W-1:0] nm1;
  logic small_hit;

  assign base = dpt_pkg::base_prime(bi_r);
  assign nm1 = n_r - 1'b1;
  assign rem2 = {rem_r, n_r[bit_r[SW-1:0]]};

  always_comb begin
    small_hit = 1'b0;
    for (int i = 0; i < dpt_pkg::BASE_COUNT; i++) begin
      if (n_r == W'(dpt_pkg::base_prime(dpt_pkg::BASE_IDX_W'(i)))) small_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dpt_pkg::ST_IDLE;
      vld_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      vld_r <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == dpt_pkg::ST_IDLE && start) n_r <= cand;
    d_r <= d_nxt; e_r <= e_nxt; p_r <= p_nxt; b_r <= b_nxt;
    s_r <= s_nxt; t_r <= t_nxt; bi_r <= bi_nxt; bit_r <= bit_nxt;
    rem_r <= rem_nxt; prime_r <= prime_nxt;
  end

  // next state and datapath control
  always_comb begin
    st_nxt = st_r;
    d_nxt = d_r; e_nxt = e_r; p_nxt = p_r; b_nxt = b_r;
    s_nxt = s_r; t_nxt = t_r; bi_nxt = bi_r; bit_nxt = bit_r;
    rem_nxt = rem_r; prime_nxt = prime_r; vld_nxt = 1'b0; pend_nxt = 1'b0;
    mul_start = 1'b0; mul_x = p_r; mul_y = b_r;
    case (st_r)
      dpt_pkg::ST_IDLE: begin
        if (start) begin
          st_nxt = dpt_pkg::ST_SMALL;
          bi_nxt = '0;
        end
      end
      dpt_pkg::ST_SMALL: begin
        if (n_r <= W'(dpt_pkg::SMALL_LIMIT)) begin
          prime_nxt = small_hit;
          st_nxt = dpt_pkg::ST_DONE;
        end else begin
          d_nxt = nm1; s_nxt = '0;
          st_nxt = dpt_pkg::ST_ODD;
        end
      end
      // strip factors of two from n-1
      dpt_pkg::ST_ODD: begin
        if (!d_r[0]) begin
          d_nxt = d_r >> 1;
          s_nxt = s_r + 1'b1;
        end else begin
          rem_nxt = '0; bit_nxt = SW'(W - 1);
          st_nxt = dpt_pkg::ST_REDUCE;
        end
      end
      // n mod base, one bit per cycle
      dpt_pkg::ST_REDUCE: begin
        rem_nxt = (rem2 >= (RW+1)'(base)) ? RW'(rem2 - (RW+1)'(base)) : RW'(rem2);
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          if (rem_nxt == '0) begin
            prime_nxt = 1'b0;
            st_nxt = dpt_pkg::ST_DONE;
          end else begin
            p_nxt = W'(1); b_nxt = W'(base); e_nxt = d_r; t_nxt = s_r;
            pend_nxt = 1'b0;
            st_nxt = dpt_pkg::ST_POW_MUL;
          end
        end
      end
      // result times base when exponent bit set
      dpt_pkg::ST_POW_MUL: begin
        pend_nxt = pend_r;
        if (e_r == '0) begin
          st_nxt = dpt_pkg::ST_CHECK;
        end else if (!e_r[0]) begin
          st_nxt = dpt_pkg::ST_POW_SQR;
        end else if (!pend_r) begin
          mul_start = 1'b1; mul_x = p_r; mul_y = b_r; pend_nxt = 1'b1;
        end else if (mul_ctl.done) begin
          p_nxt = mul_prod; pend_nxt = 1'b0;
          st_nxt = dpt_pkg::ST_POW_SQR;
        end
      end
      // square the base, shift the exponent
      dpt_pkg::ST_POW_SQR: begin
        pend_nxt = pend_r;
        mul_x = b_r; mul_y = b_r;
        if (!pend_r) begin
          mul_start = 1'b1; pend_nxt = 1'b1;
        end else if (mul_ctl.done) begin
          b_nxt = mul_prod; e_nxt = e_r >> 1; pend_nxt = 1'b0;
          st_nxt = dpt_pkg::ST_POW_MUL;
        end
      end
      dpt_pkg::ST_CHECK: begin
        if (p_r == W'(1) || p_r == nm1) st_nxt = dpt_pkg::ST_DONE;
        else st_nxt = dpt_pkg::ST_SQ_LOOP;
        prime_nxt = 1'b1;
        if (!(p_r == W'(1) || p_r == nm1)) prime_nxt = 1'b0;
        if ((p_r == W'(1) || p_r == nm1) && bi_r != dpt_pkg::BASE_IDX_W'(dpt_pkg::BASE_COUNT - 1)) begin
          bi_nxt = bi_r + 1'b1; rem_nxt = '0; bit_nxt = SW'(W - 1);
          st_nxt = dpt_pkg::ST_REDUCE;
        end
      end
      // further squarings searching for n-1
      dpt_pkg::ST_SQ_LOOP: begin
        pend_nxt = pend_r;
        mul_x = p_r; mul_y = p_r;
        if (t_r <= SW'(1)) begin
          prime_nxt = 1'b0;
          st_nxt = dpt_pkg::ST_DONE;
        end else if (!pend_r) begin
          mul_start = 1'b1; pend_nxt = 1'b1;
        end else if (mul_ctl.done) begin
          p_nxt = mul_prod; t_nxt = t_r - 1'b1; pend_nxt = 1'b0;
          if (mul_prod == nm1) begin
            prime_nxt = 1'b1;
            if (bi_r == dpt_pkg::BASE_IDX_W'(dpt_pkg::BASE_COUNT - 1)) begin
              st_nxt = dpt_pkg::ST_DONE;
            end else begin
              bi_nxt = bi_r + 1'b1; rem_nxt = '0; bit_nxt = SW'(W - 1);
              st_nxt = dpt_pkg::ST_REDUCE;
            end
          end
        end
      end
      dpt_pkg::ST_DONE: begin
        vld_nxt = 1'b1;
        st_nxt = dpt_pkg::ST_IDLE;
      end
      default: st_nxt = dpt_pkg::ST_IDLE;
    endcase
  end

  assign mul_m = n_r;
  assign busy = (st_r != dpt_pkg::ST_IDLE);
  assign res_valid = vld_r;
  assign res_prime = prime_r;

  `DPT_ASSERT(a_valid_after_done, clk, rst_n, vld_r |-> $past(st_r == dpt_pkg::ST_DONE))
  `DPT_ASSERT(a_mul_start_idle, clk, rst_n, mul_start |-> !mul_ctl.busy)
  `DPT_ASSERT(a_done_needs_pending, clk, rst_n, mul_ctl.done |-> pend_r)
endmodule
